>>> rtl/rsqe_pkg.sv
// Shared types, constants and constant functions for the rotated sprite quad expander.
// Holds the quarter-wave sine series used to build the lookup table and the vertex order.
// No dependencies.
package rsqe_pkg;

  localparam int PHASE_W = 14;
  localparam int MAG_W   = 15;
  localparam int TRIG_W  = 16;
  localparam int STEP_W  = 3;
  localparam int CORNER_W = 2;
  localparam int COLOR_W = 32;

  localparam logic [MAG_W-1:0]  ONE_Q14      = 15'd16384;
  localparam logic [15:0]       QUARTER_TURN = 16'd16384;
  localparam logic [63:0]       HALF_PI_Q30  = 64'd1686629713;

  // Divisors (2n)(2n+1) of the sine series terms, n = 1..9.
  localparam logic [63:0] TERM_DIV [9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  localparam logic [STEP_W-1:0] FIRST_STEP = 3'd0;
  localparam logic [STEP_W-1:0] LAST_STEP  = 3'd5;

  localparam logic [CORNER_W-1:0] CORNER_BL = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_BR = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_TL = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_TR = 2'd3;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // Sine of angle x (Q30 radians) in Q14, from a truncated Taylor series up to x^19.
  function automatic logic [MAG_W-1:0] taylor_sine_q14(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    longint      acc;
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= 9; n++) begin
      t = ((t * x2) >> 30) / TERM_DIV[n-1];
      if ((n & 1) != 0) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) begin
      acc = 16384;
    end
    return MAG_W'(acc);
  endfunction

  // Two triangles: corners 0,1,2 then 1,3,2.
  function automatic logic [CORNER_W-1:0] corner_of_step(input logic [STEP_W-1:0] step);
    logic [CORNER_W-1:0] c;
    unique case (step)
      3'd0:    c = CORNER_BL;
      3'd1:    c = CORNER_BR;
      3'd2:    c = CORNER_TL;
      3'd3:    c = CORNER_BR;
      3'd4:    c = CORNER_TR;
      3'd5:    c = CORNER_TL;
      default: c = CORNER_BL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/rsqe_front.sv
// Front end: accepts particles, drops inactive ones, looks up sine and cosine,
// rotates the four corner offsets and pushes one quad record per particle.
// Depends on rsqe_pkg.
module rsqe_front #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COORD_WIDTH      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic [15:0]                   in_sprite_size,
  input  logic [15:0]                   in_rotation,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  input  logic [7:0]                    in_alpha,
  input  logic                          in_particle_active,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [8*COORD_WIDTH+rsqe_pkg::COLOR_W-1:0] q_push_data
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W = rsqe_pkg::PHASE_W + IDX_W + 1;
  localparam int PRD_W  = 33;
  localparam int ACC_W  = 35;
  localparam int RND_W  = 20;
  localparam int SUM_W  = ((COORD_WIDTH > RND_W) ? COORD_WIDTH : RND_W) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Quarter-wave sine table, built at elaboration.
  logic [rsqe_pkg::MAG_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] X = (64'(k) * rsqe_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [rsqe_pkg::MAG_W-1:0] ENTRY = rsqe_pkg::taylor_sine_q14(X);
    assign sine_rom[k] = ENTRY;
  end

  logic advance;

  // Stage 1: angle folding, lane 0 is sine, lane 1 is cosine
  logic [15:0]                ang   [2];
  logic [rsqe_pkg::MAG_W-1:0] fold  [2];
  logic [PROD_W-1:0]          prod  [2];
  logic [IDX_W-1:0]           idx   [2];
  logic [1:0]                 one_c;
  logic [1:0]                 neg_c;

  always_comb begin
    ang[0] = in_rotation;
    ang[1] = in_rotation + rsqe_pkg::QUARTER_TURN;
    for (int l = 0; l < 2; l++) begin
      fold[l]  = ang[l][14] ? (rsqe_pkg::ONE_Q14 - {1'b0, ang[l][13:0]})
                            : {1'b0, ang[l][13:0]};
      one_c[l] = ang[l][14] && (ang[l][13:0] == '0);
      neg_c[l] = ang[l][15];
      prod[l]  = PROD_W'(fold[l][rsqe_pkg::PHASE_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
      idx[l]   = prod[l][rsqe_pkg::PHASE_W +: IDX_W];
    end
  end

  logic                          v1_r;
  logic signed [COORD_WIDTH-1:0] px1_r, py1_r;
  logic [15:0]                   h1_r;
  rsqe_pkg::color_t              col1_r;
  logic [IDX_W-1:0]              idx1_r [2];
  logic [1:0]                    one1_r, neg1_r;

  // Stage 2: table read
  logic                          v2_r;
  logic signed [COORD_WIDTH-1:0] px2_r, py2_r;
  logic [15:0]                   h2_r;
  rsqe_pkg::color_t              col2_r;
  logic [rsqe_pkg::MAG_W-1:0]    mag2_r [2];
  logic [1:0]                    one2_r, neg2_r;

  // Stage 3: h*cos and h*sin
  logic signed [rsqe_pkg::TRIG_W-1:0] trig [2];
  logic signed [PRD_W-1:0]            hc, hs;
  logic                               v3_r;
  logic signed [COORD_WIDTH-1:0]      px3_r, py3_r;
  rsqe_pkg::color_t                   col3_r;
  logic signed [PRD_W-1:0]            a3_r, b3_r;

  // Stage 4: corners
  logic signed [ACC_W-1:0]       a_ext, b_ext, rx, ry, rx_rnd, ry_rnd;
  logic signed [RND_W-1:0]       rx_n, ry_n;
  logic signed [SUM_W-1:0]       sx, sy;
  logic [2*COORD_WIDTH-1:0]      corner_c  [4];
  logic                          v4_r;
  rsqe_pkg::color_t              col4_r;
  logic [2*COORD_WIDTH-1:0]      corner4_r [4];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trig[l] = one2_r[l] ? $signed({1'b0, rsqe_pkg::ONE_Q14}) : $signed({1'b0, mag2_r[l]});
      if (neg2_r[l]) begin
        trig[l] = -trig[l];
      end
    end
    hc = $signed({1'b0, h2_r}) * trig[1];
    hs = $signed({1'b0, h2_r}) * trig[0];
  end

  always_comb begin
    a_ext = ACC_W'(a3_r);
    b_ext = ACC_W'(b3_r);
    rx = '0;
    ry = '0;
    rx_rnd = '0;
    ry_rnd = '0;
    rx_n = '0;
    ry_n = '0;
    sx = '0;
    sy = '0;
    for (int i = 0; i < 4; i++) begin
      // Corner offset (cx, cy): +h when the corner bit is set, -h otherwise.
      rx     = (i[0] ? a_ext : -a_ext) + (i[1] ? -b_ext : b_ext);
      ry     = (i[0] ? b_ext : -b_ext) + (i[1] ? a_ext : -a_ext);
      rx_rnd = (rx + ACC_W'(16384)) >>> 15;
      ry_rnd = (ry + ACC_W'(16384)) >>> 15;
      rx_n   = RND_W'(rx_rnd);
      ry_n   = RND_W'(ry_rnd);
      sx     = SUM_W'(rx_n) + SUM_W'(px3_r);
      sy     = SUM_W'(ry_n) + SUM_W'(py3_r);
      if (sx > SAT_HI) begin
        sx = SAT_HI;
      end else if (sx < SAT_LO) begin
        sx = SAT_LO;
      end
      if (sy > SAT_HI) begin
        sy = SAT_HI;
      end else if (sy < SAT_LO) begin
        sy = SAT_LO;
      end
      corner_c[i] = {sy[COORD_WIDTH-1:0], sx[COORD_WIDTH-1:0]};
    end
  end

  // Whole pipe moves together; it holds only when the last stage cannot drain.
  assign advance  = !v4_r || !q_full;
  assign in_stall = !advance;
  assign q_push   = v4_r && !q_full;

  always_comb begin
    q_push_data = '0;
    for (int i = 0; i < 4; i++) begin
      q_push_data[i*2*COORD_WIDTH +: 2*COORD_WIDTH] = corner4_r[i];
    end
    q_push_data[8*COORD_WIDTH +: rsqe_pkg::COLOR_W] = col4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid && in_particle_active;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      px1_r  <= in_pos_x;
      py1_r  <= in_pos_y;
      h1_r   <= in_sprite_size;
      col1_r <= '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};
      one1_r <= one_c;
      neg1_r <= neg_c;
      for (int l = 0; l < 2; l++) begin
        idx1_r[l] <= idx[l];
        mag2_r[l] <= sine_rom[idx1_r[l]];
      end
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      h2_r   <= h1_r;
      col2_r <= col1_r;
      one2_r <= one1_r;
      neg2_r <= neg1_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      col3_r <= col2_r;
      a3_r   <= hc;
      b3_r   <= hs;
      col4_r <= col3_r;
      for (int i = 0; i < 4; i++) begin
        corner4_r[i] <= corner_c[i];
      end
    end
  end

endmodule

>>> rtl/rsqe_queue.sv
// Two-entry queue of quad records between the front end and the vertex emitter.
// No package dependencies.
module rsqe_queue #(
  parameter int WIDTH = 160
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/rsqe_back.sv
// Back end: takes one quad record and emits its six vertices through an output register.
// Depends on rsqe_pkg.
module rsqe_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [8*COORD_WIDTH+rsqe_pkg::COLOR_W-1:0] q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_vertex_x,
  output logic signed [COORD_WIDTH-1:0] out_vertex_y,
  output logic [7:0]                    out_vertex_red,
  output logic [7:0]                    out_vertex_green,
  output logic [7:0]                    out_vertex_blue,
  output logic [7:0]                    out_vertex_alpha,
  output logic [1:0]                    out_corner_index,
  output logic                          out_last_of_quad
);

  localparam int QUAD_W = 8*COORD_WIDTH + rsqe_pkg::COLOR_W;

  logic                          quad_valid_r, quad_valid_nxt;
  logic [QUAD_W-1:0]             quad_r, quad_nxt;
  logic [rsqe_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] x_r, y_r, x_nxt, y_nxt;
  rsqe_pkg::color_t              col_r, col_nxt;
  logic [1:0]                    corner_r, corner_nxt;
  logic                          last_r, last_nxt;

  logic                          out_load, emit, last_step;
  logic [COORD_WIDTH-1:0]        cx [4];
  logic [COORD_WIDTH-1:0]        cy [4];
  logic [1:0]                    corner;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cx[i] = quad_r[i*2*COORD_WIDTH +: COORD_WIDTH];
      cy[i] = quad_r[i*2*COORD_WIDTH + COORD_WIDTH +: COORD_WIDTH];
    end
  end

  assign out_load  = !out_valid_r || !out_stall;
  assign emit      = quad_valid_r && out_load;
  assign last_step = (step_r == rsqe_pkg::LAST_STEP);
  assign corner    = rsqe_pkg::corner_of_step(step_r);
  // Take the next quad when none is held, or as the current one hands off its last vertex.
  assign q_pop     = q_valid && (!quad_valid_r || (emit && last_step));

  always_comb begin
    quad_valid_nxt = quad_valid_r;
    quad_nxt       = quad_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    col_nxt        = col_r;
    corner_nxt     = corner_r;
    last_nxt       = last_r;
    if (out_load) begin
      out_valid_nxt = quad_valid_r;
    end
    if (emit) begin
      x_nxt      = $signed(cx[corner]);
      y_nxt      = $signed(cy[corner]);
      col_nxt    = quad_r[8*COORD_WIDTH +: rsqe_pkg::COLOR_W];
      corner_nxt = corner;
      last_nxt   = last_step;
      if (last_step) begin
        quad_valid_nxt = 1'b0;
        step_nxt       = rsqe_pkg::FIRST_STEP;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
    if (q_pop) begin
      quad_valid_nxt = 1'b1;
      quad_nxt       = q_data;
      step_nxt       = rsqe_pkg::FIRST_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_valid_r <= 1'b0;
      step_r       <= rsqe_pkg::FIRST_STEP;
      out_valid_r  <= 1'b0;
    end else begin
      quad_valid_r <= quad_valid_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quad_r   <= quad_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    col_r    <= col_nxt;
    corner_r <= corner_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_x     = x_r;
  assign out_vertex_y     = y_r;
  assign out_vertex_red   = col_r.red;
  assign out_vertex_green = col_r.green;
  assign out_vertex_blue  = col_r.blue;
  assign out_vertex_alpha = col_r.alpha;
  assign out_corner_index = corner_r;
  assign out_last_of_quad = last_r;

endmodule

>>> rtl/rotated_sprite_quad_expand.sv
// Top level of the rotated sprite quad expander.
// Instantiates rsqe_front, rsqe_queue and rsqe_back; depends on rsqe_pkg.
//
// Usage:
//   Input channel (in_*): one particle per beat: center, edge length, angle,
//   RGBA color and an active flag. An inactive particle is taken and dropped.
//   Output channel (out_*): one vertex per beat, six per active particle, in
//   corner order 0,1,2,1,3,2; out_last_of_quad marks the sixth.
//   Path: the first vertex of a particle passes the 4 front stages, the quad
//   queue, the quad register of the emitter and the output register on its
//   way to out_valid.
//   Throughput: one vertex per cycle while out_stall is low and a quad is
//   waiting; an inactive particle takes an input beat and yields no vertex.
//   The vertex emitter and its single output register set that figure.
//   A two-entry quad queue separates the front pipe from the emitter, so
//   particles keep entering while earlier vertices still drain.
//   Stall: when out_stall is high the output register holds its vertex; the
//   emitter holds, the queue fills and then in_stall rises.
//   Reset (rst_n low, synchronous): all valids clear, the queue empties, the
//   vertex step returns to the first vertex. No clearing pass is needed.
module rotated_sprite_quad_expand #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COORD_WIDTH      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic [15:0]                   in_sprite_size,
  input  logic [15:0]                   in_rotation,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  input  logic [7:0]                    in_alpha,
  input  logic                          in_particle_active,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_vertex_x,
  output logic signed [COORD_WIDTH-1:0] out_vertex_y,
  output logic [7:0]                    out_vertex_red,
  output logic [7:0]                    out_vertex_green,
  output logic [7:0]                    out_vertex_blue,
  output logic [7:0]                    out_vertex_alpha,
  output logic [1:0]                    out_corner_index,
  output logic                          out_last_of_quad
);

  // One quad record: four {y,x} corners plus the packed color.
  localparam int QUAD_W = 8*COORD_WIDTH + rsqe_pkg::COLOR_W;

  logic              q_push, q_full, q_pop, q_not_empty;
  logic [QUAD_W-1:0] q_push_data, q_pop_data;

  // Front: accept, drop inactive particles, rotate corners
  rsqe_front #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COORD_WIDTH      (COORD_WIDTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_sprite_size     (in_sprite_size),
    .in_rotation        (in_rotation),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_alpha           (in_alpha),
    .in_particle_active (in_particle_active),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_push_data        (q_push_data)
  );

  // Queue: decouple the front pipe from the vertex emitter
  rsqe_queue #(
    .WIDTH (QUAD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // Back: advance through six vertex slots per quad
  rsqe_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_data           (q_pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_red   (out_vertex_red),
    .out_vertex_green (out_vertex_green),
    .out_vertex_blue  (out_vertex_blue),
    .out_vertex_alpha (out_vertex_alpha),
    .out_corner_index (out_corner_index),
    .out_last_of_quad (out_last_of_quad)
  );

`ifndef SYNTHESIS
  // The sixth vertex always closes the second triangle on the top-left corner.
  a_last_is_top_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_quad |-> out_corner_index == rsqe_pkg::CORNER_TL)
    else $error("last vertex of quad is not the top-left corner");

  // Inside a quad, the next vertex follows with no gap.
  a_quad_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_quad |=> out_valid)
    else $error("gap inside a quad");

  // The front must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("quad queue overflow");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotated_sprite_quad_expand: random and directed particles,
// six predicted vertices per active particle, checked beat by beat. Needs rsqe_pkg.
module tb;

  localparam int LUT_DEPTH      = 256;
  localparam int CW             = 16;
  localparam int RANDOM_ITEMS   = 160;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 24;

  // Vertex emission order: two triangles, corners 0,1,2 then 1,3,2.
  localparam logic [1:0] QUAD_ORDER [6] = '{
    rsqe_pkg::CORNER_BL, rsqe_pkg::CORNER_BR, rsqe_pkg::CORNER_TL,
    rsqe_pkg::CORNER_BR, rsqe_pkg::CORNER_TR, rsqe_pkg::CORNER_TL
  };

  typedef enum logic [1:0] {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FREE} traffic_phase_t;

  typedef struct {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic [15:0]          size;
    logic [15:0]          rotation;
    rsqe_pkg::color_t     color;
    logic                 active;
  } particle_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    rsqe_pkg::color_t     color;
    logic [1:0]           corner;
    logic                 last;
  } vertex_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid           = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_pos_x           = '0;
  logic signed [CW-1:0] in_pos_y           = '0;
  logic [15:0]          in_sprite_size     = '0;
  logic [15:0]          in_rotation        = '0;
  logic [7:0]           in_red             = '0;
  logic [7:0]           in_green           = '0;
  logic [7:0]           in_blue            = '0;
  logic [7:0]           in_alpha           = '0;
  logic                 in_particle_active = 1'b0;
  logic                 out_valid;
  logic                 out_stall          = 1'b0;
  logic signed [CW-1:0] out_vertex_x;
  logic signed [CW-1:0] out_vertex_y;
  logic [7:0]           out_vertex_red;
  logic [7:0]           out_vertex_green;
  logic [7:0]           out_vertex_blue;
  logic [7:0]           out_vertex_alpha;
  logic [1:0]           out_corner_index;
  logic                 out_last_of_quad;

  // Particles waiting for the driver, and vertices predicted but not yet seen.
  particle_t particles_to_send [$];
  vertex_t   pending_vertices [$];

  // Quarter-wave sine magnitudes in Q1.14, one per table slot.
  int quarter_sine [LUT_DEPTH];

  particle_t      on_bus;
  particle_t      next_particle;
  int             launched    = 0;
  int             total_items = 0;
  int             mismatches  = 0;
  int             vertex_seen = 0;
  int             idle_run    = 0;
  int             send_idle_pct;
  int             sink_stall_pct;
  bit             timed_out   = 1'b0;
  traffic_phase_t phase;

  rotated_sprite_quad_expand #(
    .SINE_TABLE_DEPTH(LUT_DEPTH),
    .COORD_WIDTH     (CW)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_sprite_size    (in_sprite_size),
    .in_rotation       (in_rotation),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_alpha          (in_alpha),
    .in_particle_active(in_particle_active),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vertex_x      (out_vertex_x),
    .out_vertex_y      (out_vertex_y),
    .out_vertex_red    (out_vertex_red),
    .out_vertex_green  (out_vertex_green),
    .out_vertex_blue   (out_vertex_blue),
    .out_vertex_alpha  (out_vertex_alpha),
    .out_corner_index  (out_corner_index),
    .out_last_of_quad  (out_last_of_quad)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Traffic shaping: a slow sink first, then a slow source, then full rate.
  assign phase = (launched < total_items / 3)     ? PH_SLOW_SINK :
                 (launched < 2 * total_items / 3) ? PH_SLOW_SOURCE : PH_FREE;
  assign send_idle_pct  = (phase == PH_SLOW_SINK) ? 20 :
                          (phase == PH_SLOW_SOURCE) ? 70 : 0;
  assign sink_stall_pct = (phase == PH_SLOW_SINK) ? 70 :
                          (phase == PH_SLOW_SOURCE) ? 20 : 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Table slot k: Taylor series of sin(k/depth * pi/2) in Q30, each term truncated,
  // then rounded half up to Q14 and clamped to 0..1.0.
  function automatic int series_sine(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (64'(k) * rsqe_pkg::HALF_PI_Q30) / 64'(LUT_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) begin
      acc = 16384;
    end
    return int'(acc);
  endfunction

  // Magnitude for a phase in 0..16384; a full quarter turn reads exactly 1.0.
  function automatic int quarter_mag(input int p);
    if (p >= 16384) begin
      return int'(rsqe_pkg::ONE_Q14);
    end
    return quarter_sine[(p * LUT_DEPTH) >> 14];
  endfunction

  // Mirror the phase in odd quadrants, negate in the lower half turn.
  function automatic int angle_sine(input logic [15:0] angle);
    int mag;
    mag = angle[14] ? quarter_mag(16384 - int'(angle[13:0])) : quarter_mag(int'(angle[13:0]));
    return angle[15] ? -mag : mag;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return CW'(v);
  endfunction

  // Expand one particle into its six expected vertices.
  task automatic predict_quad(input particle_t p);
    int                   s;
    int                   c;
    longint               h;
    longint               cx;
    longint               cy;
    longint               rx;
    longint               ry;
    logic signed [CW-1:0] corner_x [4];
    logic signed [CW-1:0] corner_y [4];
    vertex_t              v;
    if (!p.active) begin
      return;
    end
    s = angle_sine(p.rotation);
    c = angle_sine(p.rotation + rsqe_pkg::QUARTER_TURN);
    // The full edge length read as Q7.9 is the half-size in Q8.8 units.
    h = longint'(p.size);
    for (int i = 0; i < 4; i++) begin
      cx = (i % 2 == 1) ? h : -h;
      cy = (i >= 2) ? h : -h;
      // Q23 products, rounded half up to Q8.8 (arithmetic shift floors).
      rx = (cx * c - cy * s + 16384) >>> 15;
      ry = (cx * s + cy * c + 16384) >>> 15;
      corner_x[i] = clamp_coord(longint'(p.pos_x) + rx);
      corner_y[i] = clamp_coord(longint'(p.pos_y) + ry);
    end
    for (int k = 0; k < 6; k++) begin
      v.corner = QUAD_ORDER[k];
      v.x      = corner_x[v.corner];
      v.y      = corner_y[v.corner];
      v.color  = p.color;
      v.last   = (k == int'(rsqe_pkg::LAST_STEP));
      pending_vertices = {pending_vertices, v};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    $display("%0t ns  MISMATCH  %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("vertex %0d %s: got %h want %h", vertex_seen, name, got, want));
    end
  endtask

  task automatic check_vertex();
    vertex_t want;
    if (pending_vertices.size() == 0) begin
      flag_error($sformatf("vertex %0d arrived with nothing pending (x=%h y=%h)",
                           vertex_seen, out_vertex_x, out_vertex_y));
    end else begin
      want = pending_vertices.pop_front();
      check_field("x",      out_vertex_x,     want.x);
      check_field("y",      out_vertex_y,     want.y);
      check_field("red",    out_vertex_red,   want.color.red);
      check_field("green",  out_vertex_green, want.color.green);
      check_field("blue",   out_vertex_blue,  want.color.blue);
      check_field("alpha",  out_vertex_alpha, want.color.alpha);
      check_field("corner", out_corner_index, want.corner);
      check_field("last",   out_last_of_quad, want.last);
    end
    vertex_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold the payload while stalled, otherwise load the next particle or idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_quad(on_bus);
      end
      if (!in_valid || !in_stall) begin
        if (particles_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_particle       = particles_to_send.pop_front();
          on_bus             <= next_particle;
          in_pos_x           <= next_particle.pos_x;
          in_pos_y           <= next_particle.pos_y;
          in_sprite_size     <= next_particle.size;
          in_rotation        <= next_particle.rotation;
          in_red             <= next_particle.color.red;
          in_green           <= next_particle.color.green;
          in_blue            <= next_particle.color.blue;
          in_alpha           <= next_particle.color.alpha;
          in_particle_active <= next_particle.active;
          in_valid           <= 1'b1;
          launched           <= launched + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted vertex beat, then pick the next stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_vertex();
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_particle(input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] size, input logic [15:0] rot,
                              input logic [31:0] rgba, input logic active);
    particle_t p;
    p.pos_x    = px;
    p.pos_y    = py;
    p.size     = size;
    p.rotation = rot;
    p.color    = rgba;
    p.active   = active;
    particles_to_send = {particles_to_send, p};
  endtask

  // Mostly small sprites, with full-range, upper-half and near-maximum sizes mixed in.
  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      return 16'($urandom_range(2047));
    end else if (r < 80) begin
      return 16'($urandom_range(65535));
    end else if (r < 90) begin
      return 16'(65535 - $urandom_range(15));
    end
    return 16'($urandom_range(65535, 32768));
  endfunction

  // Angles near the quadrant boundaries now and then, otherwise anywhere.
  function automatic logic [15:0] pick_rotation();
    if ($urandom_range(99) < 15) begin
      return 16'($urandom_range(3) * 16384 + $urandom_range(4) - 2);
    end
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      return 16'(32767 - $urandom_range(255));
    end else if (r < 16) begin
      return 16'(-32768 + $urandom_range(255));
    end
    return 16'($urandom_range(65535));
  endfunction

  initial begin
    for (int k = 0; k < LUT_DEPTH; k++) begin
      quarter_sine[k] = series_sine(k);
    end

    // Directed: field extremes, quadrant points, saturation, inactive particles.
    add_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
    add_particle(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1);
    add_particle(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 32'h1234_5678, 1'b1);
    add_particle(16'h8000, 16'h8000, 16'hFFFF, 16'h8000, 32'h89AB_CDEF, 1'b1);
    add_particle(16'h0100, 16'hFF00, 16'h0100, 16'h4000, 32'hAA55_AA55, 1'b1);
    add_particle(16'h0000, 16'h0000, 16'h0100, 16'hC000, 32'h55AA_55AA, 1'b1);
    add_particle(16'h0000, 16'h0000, 16'h0100, 16'hFFFF, 32'h0F0F_0F0F, 1'b1);
    add_particle(16'h1000, 16'hF000, 16'h4000, 16'h2000, 32'hF0F0_F0F0, 1'b1);
    add_particle(16'h0000, 16'h0000, 16'h0064, 16'h0001, 32'h0102_0408, 1'b1);
    add_particle(16'h1234, 16'h5678, 16'h0200, 16'h1357, 32'hDEAD_BEEF, 1'b0);
    add_particle(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_particle(16'h7FFF, 16'h8000, 16'h03E8, 16'h3039, 32'h8040_2010, 1'b1);
    add_particle(16'h8000, 16'h7FFF, 16'h03E8, 16'hB039, 32'h1020_4080, 1'b1);
    add_particle(16'hFFFF, 16'h0001, 16'h0001, 16'h6000, 32'h7F7F_7F7F, 1'b1);
    add_particle(16'h0001, 16'hFFFF, 16'h0001, 16'hE000, 32'h8080_8080, 1'b1);
    add_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    add_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    add_particle(16'h4000, 16'hC000, 16'h8000, 16'h4001, 32'hC3C3_3C3C, 1'b1);
    add_particle(16'hC000, 16'h4000, 16'h7FFF, 16'h3FFF, 32'h3C3C_C3C3, 1'b1);
    add_particle(16'h0000, 16'h0000, 16'hFFFE, 16'h8001, 32'h00FF_00FF, 1'b1);

    // Random: mostly active particles, inactive ones interleave as noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      add_particle(pick_coord(), pick_coord(), pick_size(), pick_rotation(),
                   $urandom(), ($urandom_range(99) < 80));
    end
    total_items = particles_to_send.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Run until every particle is taken and every vertex has come back.
    while (!timed_out &&
           (particles_to_send.size() != 0 || in_valid || pending_vertices.size() != 0)) begin
      @(negedge clk);
      if (idle_run >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end

    if (timed_out) begin
      $display("%0t ns  watchdog expired after %0d quiet cycles", $realtime, idle_run);
    end else begin
      // Let any stray vertex show up before closing.
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (pending_vertices.size() != 0) begin
        flag_error($sformatf("%0d vertices never arrived", pending_vertices.size()));
      end
    end

    if (!timed_out && mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
